FILE: hdl/u8dw_pkg.sv
// ----------------------------------------------------------------------------
// u8dw_pkg: shared types and constants for the UTF-8 display width decoder
// Beat formats, the decode plan passed from decoder to emitter, and the
// display width range table.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dw_pkg;

	// Width of the saturating running width sum.
	localparam int unsigned TOTAL_BITS = 16;

	// Codepoint substituted for a bad or truncated sequence.
	localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

	// Display widths.
	localparam logic [1:0] CELL_ZERO = 2'd0;
	localparam logic [1:0] CELL_NORMAL = 2'd1;
	localparam logic [1:0] CELL_WIDE = 2'd2;

	localparam int unsigned NUM_ZERO = 5;
	localparam int unsigned NUM_WIDE = 12;

	localparam logic [20:0] ZERO_LO [NUM_ZERO] = '{
		21'h00300, 21'h01AB0, 21'h01DC0, 21'h020D0, 21'h0FE20};
	localparam logic [20:0] ZERO_HI [NUM_ZERO] = '{
		21'h0036F, 21'h01AFF, 21'h01DFF, 21'h020FF, 21'h0FE2F};

	localparam logic [20:0] WIDE_LO [NUM_WIDE] = '{
		21'h01100, 21'h02329, 21'h02E80, 21'h0AC00, 21'h0F900, 21'h0FE10,
		21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h02600, 21'h1F1E6, 21'h1F300};
	localparam logic [20:0] WIDE_HI [NUM_WIDE] = '{
		21'h0115F, 21'h0232A, 21'h0A4CF, 21'h0D7A3, 21'h0FAFF, 21'h0FE19,
		21'h0FE6F, 21'h0FF60, 21'h0FFE6, 21'h027BF, 21'h1F1FF, 21'h1FAFF};

	// One input beat.
	typedef struct packed {
		logic [7:0] text_byte;
		logic end_of_text;
	} in_beat_t;

	// One result beat.
	typedef struct packed {
		logic [20:0] codepoint;
		logic replaced;
		logic [1:0] cell_width;
		logic [15:0] total_width;
		logic last_of_text;
	} out_beat_t;

	// Results caused by one input byte: nrep replacement characters,
	// then optionally one decoded codepoint.
	typedef struct packed {
		logic [2:0] nrep;
		logic has_data;
		logic [20:0] data_cp;
		logic eot;
	} plan_t;

	// Display width of one codepoint from the fixed range table.
	function automatic logic [1:0] cell_of(input logic [20:0] cp);
		logic is_zero;
		logic is_wide;
		is_zero = (cp == 21'd0);
		is_wide = 1'b0;
		for (int i = 0; i < NUM_ZERO; i++) begin
			if (cp >= ZERO_LO[i] && cp <= ZERO_HI[i]) begin
				is_zero = 1'b1;
			end
		end
		for (int i = 0; i < NUM_WIDE; i++) begin
			if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) begin
				is_wide = 1'b1;
			end
		end
		if (is_zero) begin
			return CELL_ZERO;
		end else if (is_wide) begin
			return CELL_WIDE;
		end
		return CELL_NORMAL;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/u8dw_decoder.sv
// ----------------------------------------------------------------------------
// u8dw_decoder: UTF-8 sequence tracker
// Holds the open sequence (lead byte and buffered continuations) and turns
// each accepted byte into a plan of results for the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dw_decoder
	import u8dw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire in_beat_t in_data,
	input wire logic accept,
	output plan_t plan
);

	logic [7:0] lead_q;
	logic [7:0] pend_q [2];
	logic [1:0] pcount_q;
	logic open_q;

	logic [7:0] lead_d;
	logic [1:0] pcount_d;
	logic open_d;
	logic pend_wr;
	logic [7:0] b;
	logic cont;
	logic [1:0] need;

	// Next state and the result plan for the byte on the input.
	always_comb begin
		b = in_data.text_byte;
		cont = (b[7:6] == 2'b10);
		lead_d = lead_q;
		pcount_d = pcount_q;
		open_d = open_q;
		pend_wr = 1'b0;
		plan.nrep = 3'd0;
		plan.has_data = 1'b0;
		plan.data_cp = 21'd0;
		plan.eot = in_data.end_of_text;

		if (lead_q[7:5] == 3'b110) begin
			need = 2'd1;
		end else if (lead_q[7:4] == 4'b1110) begin
			need = 2'd2;
		end else begin
			need = 2'd3;
		end

		if (open_q && cont) begin
			if (({1'b0, pcount_q} + 3'd1) >= {1'b0, need}) begin
				// Sequence complete: assemble the codepoint.
				plan.has_data = 1'b1;
				unique case (need)
					2'd1: plan.data_cp = {10'd0, lead_q[4:0], b[5:0]};
					2'd2: plan.data_cp = {5'd0, lead_q[3:0], pend_q[0][5:0], b[5:0]};
					default: plan.data_cp = {lead_q[2:0], pend_q[0][5:0],
						pend_q[1][5:0], b[5:0]};
				endcase
				open_d = 1'b0;
				pcount_d = 2'd0;
			end else begin
				// Buffer the continuation and wait for more.
				pend_wr = 1'b1;
				pcount_d = pcount_q + 2'd1;
			end
		end else begin
			// A non-continuation breaks an open sequence.
			if (open_q) begin
				plan.nrep = 3'd1 + {1'b0, pcount_q};
				open_d = 1'b0;
				pcount_d = 2'd0;
			end
			// Decode the byte as a fresh lead.
			if (!b[7]) begin
				plan.has_data = 1'b1;
				plan.data_cp = {13'd0, b};
			end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
				open_d = 1'b1;
				lead_d = b;
				pcount_d = 2'd0;
			end else begin
				plan.nrep = plan.nrep + 3'd1;
			end
		end

		// A sequence still open at end of text is flushed.
		if (in_data.end_of_text && open_d) begin
			plan.nrep = plan.nrep + 3'd1 + {1'b0, pcount_d};
			open_d = 1'b0;
			pcount_d = 2'd0;
		end
	end

	// Sequence control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= 8'd0;
			pcount_q <= 2'd0;
			open_q <= 1'b0;
		end else if (accept) begin
			lead_q <= lead_d;
			pcount_q <= pcount_d;
			open_q <= open_d;
		end
	end

	// Continuation buffer, valid only once written.
	always_ff @(posedge clk) begin
		if (accept && pend_wr) begin
			pend_q[pcount_q[0]] <= b;
		end
	end

	a_closed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> pcount_q == 2'd0)
		else $error("continuations buffered with no sequence open");

	a_pcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		pcount_q != 2'd3)
		else $error("continuation count out of range");

	a_plan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ({1'b0, plan.nrep} + {3'd0, plan.has_data}) <= 4'd4)
		else $error("more than four results planned for one byte");

endmodule

`default_nettype wire

FILE: hdl/u8dw_emitter.sv
// ----------------------------------------------------------------------------
// u8dw_emitter: result serializer with display width and running total
// Holds one plan and sends its results through the output register, one per
// cycle while taken, looking up each width and updating the saturating sum.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dw_emitter
	import u8dw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire plan_t plan_in,
	input wire logic plan_load,
	output logic plan_free,
	output logic out_valid,
	input wire logic out_ready,
	output out_beat_t out_data
);

	plan_t plan_s1;
	logic plan_valid_s1;
	logic [TOTAL_BITS-1:0] sum_q;
	logic out_valid_q;
	out_beat_t out_q;

	logic out_load;
	logic step;
	logic last_item;
	logic cur_rep;
	logic [20:0] cur_cp;
	logic [1:0] cur_w;
	logic [TOTAL_BITS:0] sum_ext;
	logic [TOTAL_BITS-1:0] sum_sat;
	logic cur_last;
	logic plan_nonempty;

	// Pick the next result of the held plan and its width.
	always_comb begin
		out_load = !out_valid_q || out_ready;
		step = plan_valid_s1 && out_load;
		last_item = (plan_s1.nrep == 3'd1 && !plan_s1.has_data) ||
			(plan_s1.nrep == 3'd0 && plan_s1.has_data);
		cur_rep = (plan_s1.nrep != 3'd0);
		cur_cp = cur_rep ? REPLACEMENT_CP : plan_s1.data_cp;
		cur_w = cell_of(cur_cp);
		cur_last = plan_s1.eot && last_item;
		sum_ext = {1'b0, sum_q} + (TOTAL_BITS+1)'(cur_w);
		sum_sat = sum_ext[TOTAL_BITS] ? '1 : sum_ext[TOTAL_BITS-1:0];
		plan_free = !plan_valid_s1 || (step && last_item);
		plan_nonempty = (plan_in.nrep != 3'd0) || plan_in.has_data;
	end

	// Plan register: loaded from the decoder, consumed one result at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_valid_s1 <= 1'b0;
		end else if (plan_load && plan_nonempty) begin
			plan_valid_s1 <= 1'b1;
		end else if (step && last_item) begin
			plan_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (plan_load && plan_nonempty) begin
			plan_s1 <= plan_in;
		end else if (step) begin
			if (cur_rep) begin
				plan_s1.nrep <= plan_s1.nrep - 3'd1;
			end else begin
				plan_s1.has_data <= 1'b0;
			end
		end
	end

	// Running width sum, cleared after the last result of a string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				sum_q <= cur_last ? '0 : sum_sat;
			end
			if (out_load) begin
				out_valid_q <= plan_valid_s1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (step) begin
			out_q.codepoint <= cur_cp;
			out_q.replaced <= cur_rep;
			out_q.cell_width <= cur_w;
			out_q.total_width <= 16'(sum_sat);
			out_q.last_of_text <= cur_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_plan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		plan_valid_s1 |-> (plan_s1.nrep != 3'd0 || plan_s1.has_data))
		else $error("held plan has no results left");

	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		step && cur_last |=> sum_q == '0)
		else $error("width sum not cleared after end of text");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		plan_load && plan_nonempty |-> plan_free)
		else $error("plan overwritten before all results were sent");

endmodule

`default_nettype wire

FILE: hdl/utf8_decode_display_width.sv
// ----------------------------------------------------------------------------
// utf8_decode_display_width: streaming UTF-8 decoder with display widths
// Decodes a byte stream into codepoints with terminal cell widths and a
// running total width per string.
// ----------------------------------------------------------------------------
// Takes one byte per beat and gives one codepoint result per beat. A byte
// that completes a sequence or is plain ASCII produces one result, and the
// next byte is taken in the same cycle the result leaves for the output
// register, so clean text runs at one byte per cycle while the output is
// taken. Continuation bytes that extend a sequence produce no result. A byte
// that breaks a sequence, an invalid byte, or a truncation at end of text
// produces up to four results; the input then holds until the last of them
// leaves for the output register, since the single output register emits
// one result each cycle. The input also holds for every cycle in which a
// waiting result is not taken from the output. Results pass through the plan
// register and then the output register after their byte is accepted.
`default_nettype none

module utf8_decode_display_width
	import u8dw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_beat_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_beat_t out_data
);

	plan_t plan;
	logic accept;
	logic plan_free;

	// A byte is taken whenever the emitter can hold its plan.
	assign in_ready = plan_free;
	assign accept = in_valid && plan_free;

	u8dw_decoder u_decoder (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.accept(accept),
		.plan(plan)
	);

	u8dw_emitter u_emitter (
		.clk(clk),
		.arst_n(arst_n),
		.plan_in(plan),
		.plan_load(accept),
		.plan_free(plan_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

`default_nettype wire
